>>> sv/tstm_pkg.sv
// Shared constants, types and widths for the temperature trimmed-mean filter.
package tstm_pkg;

  // Window length and field widths
  localparam int WINDOW   = 10;
  localparam int SAMPLE_W = 12;
  localparam int MEAN_W   = 12;
  localparam int TEMP_W   = 18;
  localparam int SUM_W    = $clog2(WINDOW * 4095 + 1);
  localparam int CNT_W    = $clog2(WINDOW);

  // Stream data widths, padded to whole bytes
  localparam int S_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((TEMP_W + MEAN_W + 7) / 8) * 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  // Divide by WINDOW-2 as multiply by ceil(2^k / d), exact for sum < 2^SUM_W
  localparam int DIV_D     = WINDOW - 2;
  localparam int DIV_SHIFT = SUM_W + $clog2(DIV_D);
  localparam int DIV_MW    = SUM_W + 2;
  localparam longint unsigned DIV_MULT_L =
      ((64'd1 << DIV_SHIFT) + 64'(DIV_D) - 64'd1) / 64'(DIV_D);
  localparam logic [DIV_MW-1:0] DIV_MULT = DIV_MW'(DIV_MULT_L);

  // Temperature: (NUM_OFFSET - NUM_SLOPE*m) / DENOM, rounded half away from zero
  localparam int NUM_W      = 26;
  localparam int MAG_W      = 25;
  localparam int SLOPE_W    = 14;
  localparam logic signed [NUM_W-1:0] NUM_OFFSET = 26'sd15654400;
  localparam logic [SLOPE_W-1:0]      NUM_SLOPE  = 14'd8250;
  localparam int DENOM      = 174;
  localparam logic [MAG_W-1:0] ROUND_BIAS = MAG_W'(DENOM / 2);

  // Divide by DENOM as multiply by reciprocal, exact for magnitude < 2^MAG_W
  localparam int T_SHIFT = MAG_W + 8;
  localparam int T_MW    = 26;
  localparam int Q_W     = 17;
  localparam longint unsigned T_MULT_L =
      ((64'd1 << T_SHIFT) + 64'(DENOM) - 64'd1) / 64'(DENOM);
  localparam logic [T_MW-1:0] T_MULT = T_MW'(T_MULT_L);

  // Completed window handed from front to queue
  typedef struct packed {
    logic             vld;
    logic [SUM_W-1:0] trim_sum;
  } win_t;

endpackage

>>> sv/temp_sensor_trimmed_mean_top.sv
// Top level of the temperature-sensor trimmed-mean filter.
//
// Channel   Dir  Fields (tdata, lowest bit up)
// s_axis    in   adc_sample[11:0], zero pad to 16 bits
// m_axis    out  temperature_q8[17:0] (signed), trimmed_mean[29:18], zero pad to 32
//
// One sample is accepted per cycle while the queue has room; every WINDOW-th
// sample closes a window. A result passes through the queue, then the divide
// multiply, slope multiply, round, reciprocal multiply and output register.
// Reset returns the window to empty and drops any queued or pending result.
// The two-entry queue lets samples continue while a result waits on m_axis;
// s_axis stalls only when the queue holds two finished windows.
module temp_sensor_trimmed_mean_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tstm_pkg::S_DATA_W-1:0]   s_axis_tdata,   // adc_sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tstm_pkg::M_DATA_W-1:0]   m_axis_tdata    // temperature_q8, trimmed_mean
);
  import tstm_pkg::*;

  win_t                     push;
  logic                     full, q_valid, q_pop;
  logic [SUM_W-1:0]         q_data;
  logic signed [TEMP_W-1:0] temp;
  logic [MEAN_W-1:0]        mean;

  tstm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .in_ready_o  (s_axis_tready),
    .full_i      (full),
    .push_o      (push)
  );

  tstm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  tstm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_temp_o  (temp),
    .out_mean_o  (mean)
  );

  // Pack result fields
  assign m_axis_tdata = M_DATA_W'({mean, temp});

endmodule

>>> sv/tstm_front.sv
// Front end: accepts samples, tracks sum, min, max and count of the window.
module tstm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [tstm_pkg::SAMPLE_W-1:0]   in_sample_i,
  output logic                            in_ready_o,
  input  logic                            full_i,
  output tstm_pkg::win_t                  push_o
);
  import tstm_pkg::*;

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d, sum_new;
  logic [SAMPLE_W-1:0] min_q, min_d, min_new;
  logic [SAMPLE_W-1:0] max_q, max_d, max_new;
  logic                accept, last;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (cnt_q == CNT_W'(WINDOW - 1));

  // Window statistics including the incoming sample
  assign sum_new = sum_q + SUM_W'(in_sample_i);
  assign min_new = (in_sample_i < min_q) ? in_sample_i : min_q;
  assign max_new = (in_sample_i > max_q) ? in_sample_i : max_q;

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    min_d = min_q;
    max_d = max_q;
    push_o.vld      = 1'b0;
    push_o.trim_sum = sum_new - SUM_W'(min_new) - SUM_W'(max_new);
    if (accept) begin
      if (last) begin
        push_o.vld = 1'b1;
        cnt_d = '0;
        sum_d = '0;
        min_d = SAMPLE_MAX;
        max_d = '0;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
        sum_d = sum_new;
        min_d = min_new;
        max_d = max_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      min_q <= SAMPLE_MAX;
      max_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

>>> sv/tstm_queue.sv
// Two-entry queue of completed window sums between front and back.
module tstm_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tstm_pkg::win_t              push_i,
  output logic                        full_o,
  input  logic                        pop_i,
  output logic                        valid_o,
  output logic [tstm_pkg::SUM_W-1:0]  data_o
);
  import tstm_pkg::*;

  logic [SUM_W-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.vld && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.trim_sum;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> sv/tstm_back.sv
// Back end: divides the trimmed sum and converts the mean to Q8 degrees.
module tstm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  logic [tstm_pkg::SUM_W-1:0]        q_data_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tstm_pkg::TEMP_W-1:0] out_temp_o,
  output logic [tstm_pkg::MEAN_W-1:0]       out_mean_o
);
  import tstm_pkg::*;

  logic                       adv;
  logic                       v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [SUM_W+DIV_MW-1:0]    p1_q;
  logic [MEAN_W-1:0]          mean_c, m2_q, m3_q, m4_q, m5_q;
  logic [NUM_W-1:0]           p2_q;
  logic signed [NUM_W-1:0]    num_c;
  logic [NUM_W-1:0]           abs_c;
  logic                       neg3_q, neg4_q;
  logic [MAG_W-1:0]           mag3_q;
  logic [MAG_W+T_MW-1:0]      p4_q;
  logic [TEMP_W-1:0]          q_c;
  logic signed [TEMP_W-1:0]   temp5_q;

  // Whole pipeline moves while the output register is free or being drained
  assign adv     = !v5_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;

  assign mean_c = p1_q[DIV_SHIFT +: MEAN_W];
  assign num_c  = NUM_OFFSET - $signed(p2_q);
  assign abs_c  = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
  assign q_c    = {1'b0, p4_q[T_SHIFT +: Q_W]};

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q    <= (SUM_W+DIV_MW)'(q_data_i) * (SUM_W+DIV_MW)'(DIV_MULT);
      m2_q    <= mean_c;
      p2_q    <= NUM_W'(mean_c) * NUM_W'(NUM_SLOPE);
      m3_q    <= m2_q;
      neg3_q  <= num_c[NUM_W-1];
      mag3_q  <= abs_c[MAG_W-1:0] + ROUND_BIAS;
      m4_q    <= m3_q;
      neg4_q  <= neg3_q;
      p4_q    <= (MAG_W+T_MW)'(mag3_q) * (MAG_W+T_MW)'(T_MULT);
      m5_q    <= m4_q;
      temp5_q <= neg4_q ? $signed(-q_c) : $signed(q_c);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign out_temp_o  = temp5_q;
  assign out_mean_o  = m5_q;

endmodule

>>> sv/tstm_checker.sv
// Port-level checker for the trimmed-mean filter, bound to the top level.
module tstm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tstm_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import tstm_pkg::*;

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Mean at or below the zero crossing gives a non-negative temperature
  a_sign_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[TEMP_W +: MEAN_W] <= 12'd1897)
      |-> !m_axis_tdata[TEMP_W-1])
    else $error("temperature sign does not match mean");

  // Mean above the zero crossing gives a negative temperature
  a_sign_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[TEMP_W +: MEAN_W] > 12'd1897)
      |-> m_axis_tdata[TEMP_W-1])
    else $error("temperature sign does not match mean");

endmodule

bind temp_sensor_trimmed_mean_top tstm_checker u_tstm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/temp_sensor_trimmed_mean_top_tb.sv
// Self-checking testbench for the temperature-sensor trimmed-mean filter top level.
`timescale 1ns / 100ps

module temp_sensor_trimmed_mean_top_tb;
  import tstm_pkg::*;

  // Conversion constants: temp_q8 = (OFFSET_Q - SLOPE_Q*mean) / SCALE_DEN, rounded
  localparam longint OFFSET_Q  = 15654400;
  localparam longint SLOPE_Q   = 8250;
  localparam longint SCALE_DEN = 174;

  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 800;

  typedef struct {
    logic signed [TEMP_W-1:0] temp_q8;
    logic [MEAN_W-1:0]        mean;
  } temp_result_t;

  // Window predictor and store of expected temperature results
  class window_scoreboard;
    int unsigned         win_cnt;
    int unsigned         win_sum;
    logic [SAMPLE_W-1:0] win_min;
    logic [SAMPLE_W-1:0] win_max;
    temp_result_t        expected_q[$];
    int unsigned         errors;

    function new();
      win_cnt = 0;
      win_sum = 0;
      win_min = SAMPLE_MAX;
      win_max = '0;
      errors  = 0;
    endfunction

    // Fold one accepted sample into the window; closing sample queues a result
    function void note_sample(logic [SAMPLE_W-1:0] s);
      int unsigned  trimmed;
      longint       num;
      longint       q;
      temp_result_t r;
      win_sum += s;
      if (s < win_min) win_min = s;
      if (s > win_max) win_max = s;
      win_cnt++;
      if (win_cnt == WINDOW) begin
        trimmed = (win_sum - win_min - win_max) / (WINDOW - 2);
        num     = OFFSET_Q - SLOPE_Q * longint'(trimmed);
        // round to nearest, ties away from zero
        if (num >= 0) q = (num + SCALE_DEN / 2) / SCALE_DEN;
        else          q = -((-num + SCALE_DEN / 2) / SCALE_DEN);
        r.temp_q8 = TEMP_W'(q);
        r.mean    = MEAN_W'(trimmed);
        expected_q.push_back(r);
        win_cnt = 0;
        win_sum = 0;
        win_min = SAMPLE_MAX;
        win_max = '0;
      end
    endfunction

    // Compare one result transaction against the oldest expectation
    function void check_result(logic [M_DATA_W-1:0] data);
      temp_result_t             r;
      logic signed [TEMP_W-1:0] got_temp;
      logic [MEAN_W-1:0]        got_mean;
      got_temp = data[TEMP_W-1:0];
      got_mean = data[TEMP_W +: MEAN_W];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual temp %0d mean %0d",
                 $time, got_temp, got_mean);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (got_temp !== r.temp_q8) begin
        $display("%0t: temperature_q8 mismatch, expected %0d, actual %0d",
                 $time, r.temp_q8, got_temp);
        errors++;
      end
      if (got_mean !== r.mean) begin
        $display("%0t: trimmed_mean mismatch, expected %0d, actual %0d",
                 $time, r.mean, got_mean);
        errors++;
      end
      if (data[M_DATA_W-1:TEMP_W+MEAN_W] !== '0) begin
        $display("%0t: tdata pad mismatch, expected 0, actual %0h",
                 $time, data[M_DATA_W-1:TEMP_W+MEAN_W]);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  window_scoreboard sb;
  bit               quiet     = 1'b0;  // no idling on either side while set
  int unsigned      idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  temp_sensor_trimmed_mean_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Present one sample after an optional gap and hold it until accepted
  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'(s);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Random sample; the window style shapes the spread of values
  function automatic logic [SAMPLE_W-1:0] random_sample(int unsigned style,
                                                        int unsigned base);
    int unsigned lo;
    int unsigned hi;
    case (style)
      0: begin
        return SAMPLE_W'($urandom_range(0, 4095));
      end
      1: begin
        // values around a base level, small noise
        lo = (base > 16) ? base - 16 : 0;
        hi = (base < 4079) ? base + 16 : 4095;
        return SAMPLE_W'($urandom_range(hi, lo));
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return SAMPLE_MAX;
          default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
      end
      default: begin
        // constant level with an occasional outlier
        if ($urandom_range(0, 9) == 0) return SAMPLE_W'($urandom_range(0, 4095));
        return SAMPLE_W'(base);
      end
    endcase
  endfunction

  // Result side: random stalls
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Transaction monitors
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata[SAMPLE_W-1:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("temp_sensor_trimmed_mean_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned style;
    int unsigned base;
    bit          paused;
    sb = new();
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full-scale window, zero window, then mixed extremes
    repeat (WINDOW) send_sample(SAMPLE_MAX);
    repeat (WINDOW) send_sample('0);
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(12'd2048);
    send_sample(12'd1);
    send_sample(12'd4094);

    // Random windows of differing character
    style = 0;
    base  = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % WINDOW == 0) begin
        style = $urandom_range(0, 3);
        base  = $urandom_range(0, 4095);
      end
      quiet = (i >= 200 && i < 300);
      if (!paused && i >= 400 && sb.expected_q.size() != 0) begin
        // hold off until every pending result has drained
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk_i);
      end
      send_sample(random_sample(style, base));
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("temp_sensor_trimmed_mean_top regression: pass");
    end else begin
      $display("temp_sensor_trimmed_mean_top regression: fail");
    end
    $finish;
  end

endmodule
